// ----- src/decode_register_read_scoreboard_assert.svh -----
// Assertion macros for the decode register-read scoreboard.
`ifndef DECODE_REGISTER_READ_SCOREBOARD_ASSERT_SVH
`define DECODE_REGISTER_READ_SCOREBOARD_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define DRR_ASSERT_IMP(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define DRR_ASSERT_NXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/drr_pkg.sv -----
// Package: types, codes and helpers of the decode register-read scoreboard.
package drr_pkg;

    localparam int NUM_REGS   = 16;
    localparam int DATA_WIDTH = 8;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int HAZ_W      = 5;
    localparam logic [HAZ_W-1:0] HAZ_MAX = 5'd31;

    localparam logic [1:0] OPC_DECODE = 2'd0;
    localparam logic [1:0] OPC_WB     = 2'd1;
    localparam logic [1:0] OPC_BRANCH = 2'd2;

    localparam logic [3:0] OP_ALU0  = 4'd0;
    localparam logic [3:0] OP_ALU1  = 4'd1;
    localparam logic [3:0] OP_ALU2  = 4'd2;
    localparam logic [3:0] OP_INC   = 4'd3;
    localparam logic [3:0] OP_LOG4  = 4'd4;
    localparam logic [3:0] OP_LOG5  = 4'd5;
    localparam logic [3:0] OP_NOT   = 4'd6;
    localparam logic [3:0] OP_LOG7  = 4'd7;
    localparam logic [3:0] OP_LOAD  = 4'd8;
    localparam logic [3:0] OP_STORE = 4'd9;
    localparam logic [3:0] OP_JUMP  = 4'd10;
    localparam logic [3:0] OP_BRZ   = 4'd11;
    localparam logic [3:0] OP_HALT  = 4'd15;

    localparam logic [2:0] CLS_NONE  = 3'd0;
    localparam logic [2:0] CLS_ARITH = 3'd1;
    localparam logic [2:0] CLS_LOGIC = 3'd2;
    localparam logic [2:0] CLS_LOAD  = 3'd3;
    localparam logic [2:0] CLS_STORE = 3'd4;
    localparam logic [2:0] CLS_JUMP  = 3'd5;
    localparam logic [2:0] CLS_BRZ   = 3'd6;
    localparam logic [2:0] CLS_HALT  = 3'd7;

    typedef struct packed {
        logic signed [7:0] wb_value;
        logic [3:0]        wb_register;
        logic              check_hazards;
        logic              fetch_valid;
        logic [15:0]       instruction;
        logic [1:0]        opcode;
    } item_t;

    typedef struct packed {
        logic [HAZ_W-1:0] hazard_count;
        logic [7:0]       target_address;
        logic [3:0]       mem_offset;
        logic [3:0]       dest_register;
        logic [7:0]       source_two;
        logic [7:0]       source_one;
        logic [1:0]       sub_operation;
        logic [3:0]       op_field;
        logic [2:0]       op_class;
        logic             stall_res;
        logic             out_valid;
    } result_t;

    typedef struct packed {
        logic                  en;
        logic [3:0]            addr;
        logic [DATA_WIDTH-1:0] data;
    } wr_port_t;

    function automatic logic in_range(input logic [3:0] r);
        return {1'b0, r} < 5'(NUM_REGS);
    endfunction

    // First operand register: field a for increment, store and branch-if-zero, else b.
    function automatic logic [3:0] src_one(input logic [15:0] ins);
        logic [3:0] op;
        op = ins[15:12];
        if (op == OP_INC || op == OP_STORE || op == OP_BRZ)
            return ins[11:8];
        return ins[7:4];
    endfunction

    // Second operand register: b for store, else c.
    function automatic logic [3:0] src_two(input logic [15:0] ins);
        if (ins[15:12] == OP_STORE)
            return ins[7:4];
        return ins[3:0];
    endfunction

endpackage

// ----- src/drr_regfile.sv -----
// Register value memory with registered dual read and write forwarding.
module drr_regfile (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  drr_pkg::wr_port_t              wr,
    input  logic                           rd_en,
    input  logic [3:0]                     rd_addr1,
    input  logic [3:0]                     rd_addr2,
    output logic [drr_pkg::DATA_WIDTH-1:0] rd_data1,
    output logic [drr_pkg::DATA_WIDTH-1:0] rd_data2
);

    logic [drr_pkg::DATA_WIDTH-1:0] mem [drr_pkg::NUM_REGS];
    logic [drr_pkg::NUM_REGS-1:0]   written_reg;
    logic [drr_pkg::DATA_WIDTH-1:0] rd_data1_reg;
    logic [drr_pkg::DATA_WIDTH-1:0] rd_data2_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr[drr_pkg::IDX_W-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr.en) begin
            written_reg[wr.addr[drr_pkg::IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr.en && wr.addr == rd_addr1) begin
                rd_data1_reg <= wr.data;
            end else if (drr_pkg::in_range(rd_addr1)
                         && written_reg[rd_addr1[drr_pkg::IDX_W-1:0]]) begin
                rd_data1_reg <= mem[rd_addr1[drr_pkg::IDX_W-1:0]];
            end else begin
                rd_data1_reg <= '0;
            end
            if (wr.en && wr.addr == rd_addr2) begin
                rd_data2_reg <= wr.data;
            end else if (drr_pkg::in_range(rd_addr2)
                         && written_reg[rd_addr2[drr_pkg::IDX_W-1:0]]) begin
                rd_data2_reg <= mem[rd_addr2[drr_pkg::IDX_W-1:0]];
            end else begin
                rd_data2_reg <= '0;
            end
        end
    end

    assign rd_data1 = rd_data1_reg;
    assign rd_data2 = rd_data2_reg;

endmodule

// ----- src/drr_sboard.sv -----
// Scoreboard state and single-pass decode of one word.
module drr_sboard (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fire,
    input  drr_pkg::item_t                 item,
    input  logic [drr_pkg::DATA_WIDTH-1:0] rd_data1,
    input  logic [drr_pkg::DATA_WIDTH-1:0] rd_data2,
    output drr_pkg::result_t               res,
    output drr_pkg::wr_port_t              wr
);

    logic [drr_pkg::NUM_REGS-1:0] ready_reg, ready_next;
    logic [drr_pkg::NUM_REGS-1:0] flag_reg, flag_next;
    logic [drr_pkg::HAZ_W-1:0]    pend_reg, pend_next;
    logic                         branch_reg, branch_next;
    logic                         halt_reg, halt_next;

    logic [3:0] op, ra, rb, rc, r1, r2;
    logic       ok1, ok2, need1, need2, nr1, add2, st, early;
    logic [1:0] add_cnt;
    logic [drr_pkg::HAZ_W:0] sum;

    always_comb begin
        op = item.instruction[15:12];
        ra = item.instruction[11:8];
        rb = item.instruction[7:4];
        rc = item.instruction[3:0];
        r1 = drr_pkg::src_one(item.instruction);
        r2 = drr_pkg::src_two(item.instruction);
        ok1 = !drr_pkg::in_range(r1) || ready_reg[r1[drr_pkg::IDX_W-1:0]];
        ok2 = !drr_pkg::in_range(r2) || ready_reg[r2[drr_pkg::IDX_W-1:0]];
        need1 = (op <= drr_pkg::OP_STORE) || (op == drr_pkg::OP_BRZ);
        need2 = ((op <= drr_pkg::OP_LOG7) && op != drr_pkg::OP_INC
                 && op != drr_pkg::OP_NOT) || (op == drr_pkg::OP_STORE);
        nr1 = need1 && !ok1;
        add2 = need2 && !ok2 && (r1 != r2);
        st = nr1 || (need2 && !ok2);
        add_cnt = {1'b0, nr1} + {1'b0, add2};
        sum = {1'b0, pend_reg} + {{(drr_pkg::HAZ_W-1){1'b0}}, add_cnt};
        early = item.check_hazards && (halt_reg || !item.fetch_valid || !branch_reg
                                       || pend_reg != '0);

        ready_next  = ready_reg;
        flag_next   = flag_reg;
        pend_next   = pend_reg;
        branch_next = branch_reg;
        halt_next   = halt_reg;
        wr          = '0;
        res         = '0;

        unique case (item.opcode)
            drr_pkg::OPC_WB: begin
                if (drr_pkg::in_range(item.wb_register)) begin
                    wr.en   = fire;
                    wr.addr = item.wb_register;
                    wr.data = drr_pkg::DATA_WIDTH'(signed'(item.wb_value));
                    ready_next[item.wb_register[drr_pkg::IDX_W-1:0]] = 1'b1;
                    if (flag_reg[item.wb_register[drr_pkg::IDX_W-1:0]]) begin
                        flag_next[item.wb_register[drr_pkg::IDX_W-1:0]] = 1'b0;
                        if (pend_reg != '0)
                            pend_next = pend_reg - 1'b1;
                    end
                end
            end
            drr_pkg::OPC_BRANCH: begin
                branch_next = 1'b1;
            end
            drr_pkg::OPC_DECODE: begin
                if (early) begin
                    res.stall_res = 1'b1;
                end else begin
                    if (op == drr_pkg::OP_JUMP || op == drr_pkg::OP_BRZ)
                        branch_next = 1'b0;
                    if (op == drr_pkg::OP_HALT)
                        halt_next = 1'b1;
                    if (nr1 && drr_pkg::in_range(r1))
                        flag_next[r1[drr_pkg::IDX_W-1:0]] = 1'b1;
                    if (add2 && drr_pkg::in_range(r2))
                        flag_next[r2[drr_pkg::IDX_W-1:0]] = 1'b1;
                    pend_next = (sum > {1'b0, drr_pkg::HAZ_MAX}) ? drr_pkg::HAZ_MAX
                                                                : sum[drr_pkg::HAZ_W-1:0];
                    res.op_field = op;
                    unique case (op) inside
                        drr_pkg::OP_ALU0, drr_pkg::OP_ALU1, drr_pkg::OP_ALU2,
                        drr_pkg::OP_INC:   res.op_class = drr_pkg::CLS_ARITH;
                        drr_pkg::OP_LOG4, drr_pkg::OP_LOG5, drr_pkg::OP_NOT,
                        drr_pkg::OP_LOG7:  res.op_class = drr_pkg::CLS_LOGIC;
                        drr_pkg::OP_LOAD:  res.op_class = drr_pkg::CLS_LOAD;
                        drr_pkg::OP_STORE: res.op_class = drr_pkg::CLS_STORE;
                        drr_pkg::OP_JUMP:  res.op_class = drr_pkg::CLS_JUMP;
                        drr_pkg::OP_BRZ:   res.op_class = drr_pkg::CLS_BRZ;
                        drr_pkg::OP_HALT:  res.op_class = drr_pkg::CLS_HALT;
                        default:           res.op_class = drr_pkg::CLS_NONE;
                    endcase
                    if (st) begin
                        res.stall_res = 1'b1;
                    end else begin
                        res.out_valid = 1'b1;
                        if (op <= drr_pkg::OP_LOAD && drr_pkg::in_range(ra))
                            ready_next[ra[drr_pkg::IDX_W-1:0]] = 1'b0;
                        if (op <= drr_pkg::OP_LOG7) begin
                            res.sub_operation = op[1:0];
                            res.source_one    = rd_data1[7:0];
                            res.dest_register = ra;
                            if (need2)
                                res.source_two = rd_data2[7:0];
                        end else if (op == drr_pkg::OP_LOAD) begin
                            res.source_one = {4'b0000, ra};
                            res.source_two = rd_data1[7:0];
                            res.mem_offset = rc;
                        end else if (op == drr_pkg::OP_STORE) begin
                            res.source_one = rd_data1[7:0];
                            res.source_two = rd_data2[7:0];
                            res.mem_offset = rc;
                        end else if (op == drr_pkg::OP_JUMP) begin
                            res.target_address = {ra, rb};
                        end else if (op == drr_pkg::OP_BRZ) begin
                            res.source_one     = rd_data1[7:0];
                            res.target_address = {rb, rc};
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        res.hazard_count = pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg  <= '1;
            flag_reg   <= '0;
            pend_reg   <= '0;
            branch_reg <= 1'b1;
            halt_reg   <= 1'b0;
        end else if (fire) begin
            ready_reg  <= ready_next;
            flag_reg   <= flag_next;
            pend_reg   <= pend_next;
            branch_reg <= branch_next;
            halt_reg   <= halt_next;
        end
    end

endmodule

// ----- src/decode_register_read_scoreboard.sv -----
// Decode register-read scoreboard top level: input register, result register, handshakes.
// One word is accepted per clock when the output is not stalled, and each word returns
// exactly one result word, held first in the input register, then in the result register.
// Register operands are read from the register memory as the word enters the input
// register (a writeback leaving the input register in the same cycle is forwarded);
// decode, scoreboard update and the result are then formed combinationally into the
// result register. Backpressure on m_tready holds the input register and then s_tready.
module decode_register_read_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] instruction, [16] fetch_valid, [17] check_hazards, [21:18] wb_register,
    // [29:22] wb_value, [31:30] zero
    input  logic [31:0] s_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] out_valid, [1] stall_res, [4:2] op_class, [8:5] op_field, [10:9] sub_operation,
    // [18:11] source_one, [26:19] source_two, [30:27] dest_register, [34:31] mem_offset,
    // [42:35] target_address, [47:43] hazard_count
    output logic [47:0] m_tdata
);

    `include "decode_register_read_scoreboard_assert.svh"

    drr_pkg::item_t    s_item;
    drr_pkg::item_t    item_reg;
    drr_pkg::result_t  res;
    drr_pkg::result_t  res_reg;
    drr_pkg::wr_port_t wr;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              fire;
    logic              in_load;
    logic [drr_pkg::DATA_WIDTH-1:0] rd_data1, rd_data2;

    assign s_item = {s_tdata[29:0], s_tuser};
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            item_reg <= s_item;
        end
    end

    drr_regfile u_regfile (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .rd_en    (in_load),
        .rd_addr1 (drr_pkg::src_one(s_item.instruction)),
        .rd_addr2 (drr_pkg::src_two(s_item.instruction)),
        .rd_data1 (rd_data1),
        .rd_data2 (rd_data2)
    );

    drr_sboard u_sboard (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (item_reg),
        .rd_data1 (rd_data1),
        .rd_data2 (rd_data2),
        .res      (res),
        .wr       (wr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    `DRR_ASSERT_IMP(a_backpressure, aclk, aresetn,
                    in_valid_reg && out_valid_reg && !m_tready, !s_tready,
                    "input accepted while the pipeline is blocked")
    `DRR_ASSERT_NXT(a_fire_result, aclk, aresetn, fire, m_tvalid,
                    "processed word produced no result")
    `DRR_ASSERT_IMP(a_issue_xor_stall, aclk, aresetn, m_tvalid,
                    !(m_tdata[0] && m_tdata[1]), "result both issued and stalled")

endmodule

// ----- tb/decode_register_read_scoreboard_test.sv -----
// Self-checking testbench for the decode register-read scoreboard stage.
module decode_register_read_scoreboard_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OPC_NOP = 2'd3;
    localparam int MAIN_WORDS  = 560;
    localparam int HOLD_CYCLES = 60;

    typedef enum logic [1:0] {MIX_MAIN, MIX_PILE, MIX_DRAIN} mix_t;

    typedef struct {
        drr_pkg::item_t   it;
        logic             typed;
        drr_pkg::result_t want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // predicted scoreboard state
    logic [7:0]  reg_val [16];
    logic [15:0] reg_ready;
    logic [15:0] hz_flag;
    logic [4:0]  pend;
    logic        br_done;
    logic        halted_q;

    drr_pkg::result_t predicted [$];
    row_t    rows [$];
    int      late_start;
    int      fails = 0;
    int      n_words = 0;
    int      n_issued = 0;
    int      n_stalled = 0;
    int      n_writebacks = 0;
    int      peak_hazards = 0;
    logic    hold_req = 1'b0;
    logic    steady = 1'b0;

    decode_register_read_scoreboard u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [15:0] operand_regs(input logic [15:0] ins);
        logic [15:0] ra, rb, rc;
        ra = 16'd1 << ins[11:8];
        rb = 16'd1 << ins[7:4];
        rc = 16'd1 << ins[3:0];
        case (ins[15:12])
            drr_pkg::OP_INC, drr_pkg::OP_BRZ:   return ra;
            drr_pkg::OP_NOT, drr_pkg::OP_LOAD:  return rb;
            drr_pkg::OP_STORE:                  return ra | rb;
            drr_pkg::OP_ALU0, drr_pkg::OP_ALU1, drr_pkg::OP_ALU2,
            drr_pkg::OP_LOG4, drr_pkg::OP_LOG5, drr_pkg::OP_LOG7: return rb | rc;
            default:                            return 16'd0;
        endcase
    endfunction

    function automatic drr_pkg::result_t decode_and_score(input drr_pkg::item_t it);
        drr_pkg::result_t r;
        logic [3:0]  op, fa, fb, fc;
        logic [15:0] blocked;
        int          i;
        r = '0;
        op = it.instruction[15:12];
        fa = it.instruction[11:8];
        fb = it.instruction[7:4];
        fc = it.instruction[3:0];
        case (it.opcode)
            drr_pkg::OPC_WB: begin
                n_writebacks++;
                reg_val[it.wb_register] = it.wb_value;
                reg_ready[it.wb_register] = 1'b1;
                if (hz_flag[it.wb_register]) begin
                    hz_flag[it.wb_register] = 1'b0;
                    if (pend != 0) pend = pend - 5'd1;
                end
            end
            drr_pkg::OPC_BRANCH: br_done = 1'b1;
            drr_pkg::OPC_DECODE: begin
                if (it.check_hazards
                    && (halted_q || !it.fetch_valid || !br_done || pend != 0)) begin
                    r.stall_res = 1'b1;
                end else begin
                    blocked = operand_regs(it.instruction) & ~reg_ready;
                    for (i = 0; i < 16; i++) begin
                        if (blocked[i]) begin
                            hz_flag[i] = 1'b1;
                            if (pend != drr_pkg::HAZ_MAX) pend = pend + 5'd1;
                        end
                    end
                    r.op_field = op;
                    case (op)
                        drr_pkg::OP_ALU0, drr_pkg::OP_ALU1, drr_pkg::OP_ALU2,
                        drr_pkg::OP_INC:   r.op_class = drr_pkg::CLS_ARITH;
                        drr_pkg::OP_LOG4, drr_pkg::OP_LOG5, drr_pkg::OP_NOT,
                        drr_pkg::OP_LOG7:  r.op_class = drr_pkg::CLS_LOGIC;
                        drr_pkg::OP_LOAD:  r.op_class = drr_pkg::CLS_LOAD;
                        drr_pkg::OP_STORE: r.op_class = drr_pkg::CLS_STORE;
                        drr_pkg::OP_JUMP:  r.op_class = drr_pkg::CLS_JUMP;
                        drr_pkg::OP_BRZ:   r.op_class = drr_pkg::CLS_BRZ;
                        drr_pkg::OP_HALT:  r.op_class = drr_pkg::CLS_HALT;
                        default:           r.op_class = drr_pkg::CLS_NONE;
                    endcase
                    // branch state and halt change even when the operand read stalls
                    if (op == drr_pkg::OP_JUMP || op == drr_pkg::OP_BRZ) br_done = 1'b0;
                    if (op == drr_pkg::OP_HALT) halted_q = 1'b1;
                    if (blocked != 0) begin
                        r.stall_res = 1'b1;
                    end else begin
                        r.out_valid = 1'b1;
                        if (!op[3]) begin
                            r.sub_operation = op[1:0];
                            r.dest_register = fa;
                            r.source_one = (op == drr_pkg::OP_INC) ? reg_val[fa]
                                                                    : reg_val[fb];
                            r.source_two = (op == drr_pkg::OP_INC || op == drr_pkg::OP_NOT)
                                           ? 8'd0 : reg_val[fc];
                            reg_ready[fa] = 1'b0;
                        end else begin
                            case (op)
                                drr_pkg::OP_LOAD: begin
                                    r.source_one = {4'd0, fa};
                                    r.source_two = reg_val[fb];
                                    r.mem_offset = fc;
                                    reg_ready[fa] = 1'b0;
                                end
                                drr_pkg::OP_STORE: begin
                                    r.source_one = reg_val[fa];
                                    r.source_two = reg_val[fb];
                                    r.mem_offset = fc;
                                end
                                drr_pkg::OP_JUMP: r.target_address = it.instruction[11:4];
                                drr_pkg::OP_BRZ: begin
                                    r.source_one = reg_val[fa];
                                    r.target_address = it.instruction[7:0];
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            default: ;
        endcase
        r.hazard_count = pend;
        n_words++;
        n_issued += r.out_valid;
        n_stalled += r.stall_res;
        if (pend > peak_hazards) peak_hazards = pend;
        return r;
    endfunction

    function automatic drr_pkg::item_t dec(input logic [15:0] ins, input logic fv,
                                           input logic chk);
        drr_pkg::item_t it;
        it = '0;
        it.opcode = drr_pkg::OPC_DECODE;
        it.instruction = ins;
        it.fetch_valid = fv;
        it.check_hazards = chk;
        return it;
    endfunction

    function automatic drr_pkg::item_t wbk(input logic [3:0] r, input logic [7:0] v);
        drr_pkg::item_t it;
        it = '0;
        it.opcode = drr_pkg::OPC_WB;
        it.wb_register = r;
        it.wb_value = v;
        return it;
    endfunction

    function automatic drr_pkg::item_t ctl(input logic [1:0] opc);
        drr_pkg::item_t it;
        it = '0;
        it.opcode = opc;
        return it;
    endfunction

    function automatic drr_pkg::result_t plain_result(input logic ov, input logic st,
                                             input logic [2:0] cls, input logic [3:0] opf,
                                             input logic [7:0] tgt, input logic [4:0] hc);
        drr_pkg::result_t r;
        r = '0;
        r.out_valid = ov;
        r.stall_res = st;
        r.op_class = cls;
        r.op_field = opf;
        r.target_address = tgt;
        r.hazard_count = hc;
        return r;
    endfunction

    task automatic add_row(input drr_pkg::item_t it, input logic typed = 1'b0,
                           input drr_pkg::result_t want = '0);
        row_t rw;
        rw.it = it;
        rw.typed = typed;
        rw.want = want;
        rows.push_back(rw);
    endtask

    // Main mix keeps hazard_count equal to the number of flagged registers so that
    // checked decodes keep getting through; pile-up and drain drop that guard.
    function automatic drr_pkg::item_t random_word(input mix_t mix);
        drr_pkg::item_t it;
        int         roll, k;
        logic [3:0] r;
        it.instruction = 16'($urandom);
        it.wb_value = 8'($urandom);
        it.wb_register = 4'($urandom);
        it.fetch_valid = $urandom_range(99) < 92;
        it.check_hazards = $urandom_range(99) < 75;
        roll = (mix == MIX_PILE) ? 99 : $urandom_range(99);
        if (!br_done && roll < 12) begin
            it.opcode = drr_pkg::OPC_BRANCH;
        end else if (roll < 45) begin
            it.opcode = drr_pkg::OPC_WB;
            if ($urandom_range(99) < 85) begin
                for (k = 0; k < 16; k++) begin
                    r = 4'($urandom);
                    if (hz_flag[r] || (!reg_ready[r] && !hz_flag[it.wb_register]))
                        it.wb_register = r;
                end
            end
        end else if (roll < 50) begin
            it.opcode = OPC_NOP;
        end else if (roll < 55) begin
            it.opcode = drr_pkg::OPC_BRANCH;
        end else begin
            it.opcode = drr_pkg::OPC_DECODE;
            if (mix == MIX_PILE) it.check_hazards = 1'b0;
            if (mix == MIX_MAIN) begin
                if (it.instruction[15:12] == drr_pkg::OP_HALT)
                    it.instruction[15:12] = 4'($urandom_range(14));
                if (!it.check_hazards && (operand_regs(it.instruction) & hz_flag) != 0)
                    it.check_hazards = 1'b1;
            end
        end
        return it;
    endfunction

    task automatic send_word(input drr_pkg::item_t it, input logic typed,
                             input drr_pkg::result_t want);
        drr_pkg::result_t pred;
        while (!steady && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.opcode;
        s_tdata  <= {2'b00, it.wb_value, it.wb_register, it.check_hazards,
                     it.fetch_valid, it.instruction};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = decode_and_score(it);
        predicted.push_back(typed ? want : pred);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s expected %0h, got %0h", $realtime, name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge aclk) begin
        drr_pkg::result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = drr_pkg::result_t'(m_tdata);
            if (predicted.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %0h",
                         $realtime, m_tdata);
                fails++;
            end else begin
                exp_r = predicted.pop_front();
                cmp_field("out_valid",      exp_r.out_valid,      got.out_valid);
                cmp_field("stall_res",      exp_r.stall_res,      got.stall_res);
                cmp_field("op_class",       exp_r.op_class,       got.op_class);
                cmp_field("op_field",       exp_r.op_field,       got.op_field);
                cmp_field("sub_operation",  exp_r.sub_operation,  got.sub_operation);
                cmp_field("source_one",     exp_r.source_one,     got.source_one);
                cmp_field("source_two",     exp_r.source_two,     got.source_two);
                cmp_field("dest_register",  exp_r.dest_register,  got.dest_register);
                cmp_field("mem_offset",     exp_r.mem_offset,     got.mem_offset);
                cmp_field("target_address", exp_r.target_address, got.target_address);
                cmp_field("hazard_count",   exp_r.hazard_count,   got.hazard_count);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= steady || ($urandom_range(99) >= 9);
        end
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d result words outstanding", predicted.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int n, k;
        for (k = 0; k < 16; k++) reg_val[k] = '0;
        reg_ready = '1;
        hz_flag = '0;
        pend = '0;
        br_done = 1'b1;
        halted_q = 1'b0;

        add_row(dec(16'h0123, 1'b0, 1'b1), 1'b1,
                plain_result(0, 1, drr_pkg::CLS_NONE, 0, 0, 0));
        add_row(wbk(4'd0, 8'h80), 1'b1, plain_result(0, 0, drr_pkg::CLS_NONE, 0, 0, 0));
        add_row(ctl(OPC_NOP), 1'b1, plain_result(0, 0, drr_pkg::CLS_NONE, 0, 0, 0));
        add_row(wbk(4'd15, 8'h7f));
        add_row(dec(16'h7f0f, 1'b1, 1'b1));
        add_row(dec(16'h0000, 1'b1, 1'b1));
        add_row(dec(16'h12f0, 1'b1, 1'b1));
        add_row(dec(16'h3000, 1'b1, 1'b1), 1'b1,
                plain_result(0, 1, drr_pkg::CLS_NONE, 0, 0, 2));
        add_row(wbk(4'd0, 8'h05));
        add_row(wbk(4'd15, 8'hff));
        add_row(dec(16'h3100, 1'b1, 1'b1));
        add_row(dec(16'h2811, 1'b1, 1'b1));    // same register twice: counted once
        add_row(wbk(4'd1, 8'h55));
        add_row(dec(16'h6e10, 1'b1, 1'b1));
        add_row(dec(16'h8a2f, 1'b1, 1'b1));
        add_row(dec(16'h9ae5, 1'b1, 1'b1));
        add_row(wbk(4'd10, 8'h01));
        add_row(wbk(4'd14, 8'hfe));
        add_row(dec(16'h9ae5, 1'b1, 1'b1));
        add_row(dec(16'hacf0, 1'b1, 1'b1), 1'b1,
                plain_result(1, 0, drr_pkg::CLS_JUMP, drr_pkg::OP_JUMP, 8'hcf, 0));
        add_row(dec(16'h0000, 1'b1, 1'b1), 1'b1,
                plain_result(0, 1, drr_pkg::CLS_NONE, 0, 0, 0));
        add_row(dec(16'ha123, 1'b1, 1'b0), 1'b1,
                plain_result(1, 0, drr_pkg::CLS_JUMP, drr_pkg::OP_JUMP, 8'h12, 0));
        add_row(dec(16'h0d00, 1'b1, 1'b0));
        add_row(dec(16'hbd7f, 1'b1, 1'b0));    // branch-if-zero stalls during branch
        add_row(ctl(drr_pkg::OPC_BRANCH));
        add_row(wbk(4'd13, 8'h7f));
        add_row(dec(16'hbd7f, 1'b1, 1'b1));
        add_row(ctl(drr_pkg::OPC_BRANCH));
        add_row(dec(16'he5a5, 1'b1, 1'b1));
        late_start = rows.size();
        add_row(dec(16'hf000, 1'b1, 1'b0));
        add_row(dec(16'h0123, 1'b1, 1'b1));
        add_row(dec(16'hffff, 1'b1, 1'b0));
        add_row(dec(16'hc000, 1'b0, 1'b0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < late_start; k++) send_word(rows[k].it, rows[k].typed, rows[k].want);
        for (n = 0; n < MAIN_WORDS; n++) begin
            if (n == 120) hold_req = 1'b1;
            steady = (n >= 300 && n < 420);
            if (n == 460) begin
                s_tvalid <= 1'b0;
                while (predicted.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            send_word(random_word(MIX_MAIN), 1'b0, '0);
        end
        // halt, then saturate the hazard count and drain it again
        for (k = late_start; k < rows.size(); k++)
            send_word(rows[k].it, rows[k].typed, rows[k].want);
        for (n = 0; n < 60; n++) send_word(random_word(MIX_PILE), 1'b0, '0);
        for (n = 0; n < 80; n++) send_word(random_word(MIX_DRAIN), 1'b0, '0);
        s_tvalid <= 1'b0;

        for (k = 0; k < 5000 && predicted.size() != 0; k++) @(posedge aclk);
        if (predicted.size() != 0) begin
            $display("%0t: %0d result words never arrived", $realtime, predicted.size());
            fails++;
        end
        repeat (8) @(posedge aclk);

        $display("Covered %0d words: %0d decodes issued, %0d stalled, %0d writebacks",
                 n_words, n_issued, n_stalled, n_writebacks);
        $display("Hazard count peaked at %0d, with halt, branch-pending and output hold-off",
                 peak_hazards);
        if (fails == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
